FILE: rtl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared widths, register indexes and types of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

	localparam int PIX_W          = 8;
	localparam int SUM_W          = 12;
	localparam int CFG_W          = 11;
	localparam int CFG_IDX_W      = 2;
	localparam int ROW_W          = 10;
	localparam int IN_TDATA_W     = 8;
	localparam int OUT_TDATA_W    = 16;
	localparam int DEFAULT_MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int MAX_SUM        = 2295;

	localparam logic [CFG_W-1:0] RESET_DIM = CFG_W'(1024);

	// window reaches full size once both counters reach this edge
	localparam int WIN_EDGE = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	typedef struct packed {
		logic emit;
		logic last;
	} pos_t;

endpackage

FILE: rtl/box_filter_3x3_valid.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_valid
// Path: an accepted pixel is registered in stage 1, then its sum on m_tdata.
// Throughput: one pixel per cycle unless the output stalls; the line memory read
// is registered, and a read meeting the previous pixel's write is forwarded.
// Reset: counters, window and valids clear, width and height return to 1024;
// line memory is not cleared, and entries read unwritten reach no emitted sum.
// ----------------------------------------------------------------------------
module box_filter_3x3_valid #(
	parameter int MAX_WIDTH = bf3_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bf3_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bf3_pkg::OUT_TDATA_W-1:0] m_tdata,   // [11:0] window_sum, zero fill
	output logic                            m_tlast,   // frame_last
	input  logic                            cfg_we,
	input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]       cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int DW = 2 * bf3_pkg::PIX_W;

	logic                      accept;
	logic                      adv_s1;
	logic                      v_s1;
	logic [bf3_pkg::PIX_W-1:0] pix_s1;
	logic [AW-1:0]             addr_s1;
	bf3_pkg::pos_t             pos_s1;
	logic [AW-1:0]             col;
	bf3_pkg::pos_t             pos;
	logic [DW-1:0]             rd_data;
	logic [bf3_pkg::PIX_W-1:0] top;
	logic [bf3_pkg::PIX_W-1:0] mid;
	logic [bf3_pkg::SUM_W-1:0] out_sum;

	assign adv_s1   = v_s1 && (!pos_s1.emit || !m_tvalid || m_tready);
	assign s_tready = !v_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	bf3_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.col       (col),
		.pos       (pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= s_tdata[bf3_pkg::PIX_W-1:0];
			addr_s1 <= col;
			pos_s1  <= pos;
		end
	end

	bf3_line_store #(
		.DEPTH   (MAX_WIDTH),
		.AW      (AW),
		.DW      (DW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data ({mid, pix_s1}),
		.rd_data (rd_data)
	);

	assign top = rd_data[DW-1:bf3_pkg::PIX_W];
	assign mid = rd_data[bf3_pkg::PIX_W-1:0];

	bf3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (adv_s1),
		.pos       (pos_s1),
		.top       (top),
		.mid       (mid),
		.pix       (pix_s1),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_sum   (out_sum),
		.out_last  (m_tlast)
	);

	assign m_tdata = bf3_pkg::OUT_TDATA_W'(out_sum);

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_sum <= bf3_pkg::SUM_W'(bf3_pkg::MAX_SUM)))
		else $error("window sum out of range");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted item lost before stage 1");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s1) |=> (v_s1 && $stable(pix_s1) && $stable(addr_s1)))
		else $error("stalled stage 1 item changed");

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == bf3_pkg::REG_WIDTH || cfg_index == bf3_pkg::REG_HEIGHT))
		|=> (col == '0))
		else $error("register write did not restart the frame");

endmodule

FILE: rtl/bf3_ctrl.sv
// ----------------------------------------------------------------------------
// bf3_ctrl
// Configuration registers and raster column and row counters.
// ----------------------------------------------------------------------------
module bf3_ctrl #(
	parameter int MAX_WIDTH = bf3_pkg::DEFAULT_MAX_WIDTH,
	parameter int AW        = $clog2(MAX_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bf3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          accept,
	output logic [AW-1:0]                 col,
	output bf3_pkg::pos_t                 pos
);

	localparam int CMP_W = (AW + 1 > bf3_pkg::CFG_W) ? AW + 1 : bf3_pkg::CFG_W;

	logic [bf3_pkg::CFG_W-1:0] width_q;
	logic [bf3_pkg::CFG_W-1:0] height_q;
	logic [AW-1:0]             col_q;
	logic [bf3_pkg::ROW_W-1:0] row_q;
	logic [CMP_W-1:0]          width_ext;
	logic [AW-1:0]             w_last;
	logic [bf3_pkg::ROW_W-1:0] h_last;
	logic                      clear;

	assign width_ext = CMP_W'(width_q);

	always_comb begin
		if (width_q == '0) begin
			w_last = '0;
		end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
			w_last = AW'(MAX_WIDTH - 1);
		end else begin
			w_last = AW'(width_ext - CMP_W'(1));
		end
		if (height_q == '0) begin
			h_last = '0;
		end else if (height_q > bf3_pkg::CFG_W'(bf3_pkg::MAX_HEIGHT)) begin
			h_last = bf3_pkg::ROW_W'(bf3_pkg::MAX_HEIGHT - 1);
		end else begin
			h_last = bf3_pkg::ROW_W'(height_q - bf3_pkg::CFG_W'(1));
		end
	end

	assign clear = cfg_we &&
		(cfg_index == bf3_pkg::REG_WIDTH || cfg_index == bf3_pkg::REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bf3_pkg::RESET_DIM;
			height_q <= bf3_pkg::RESET_DIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bf3_pkg::REG_WIDTH:  width_q  <= cfg_data;
				bf3_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + bf3_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign col      = col_q;
	assign pos.emit = (row_q >= bf3_pkg::ROW_W'(bf3_pkg::WIN_EDGE)) &&
		(col_q >= AW'(bf3_pkg::WIN_EDGE));
	assign pos.last = (row_q == h_last) && (col_q == w_last);

endmodule

FILE: rtl/bf3_line_store.sv
// ----------------------------------------------------------------------------
// bf3_line_store
// Line memory holding the two rows above the current one, with a registered
// read and new-data forwarding when read and write hit the same entry.
// ----------------------------------------------------------------------------
module bf3_line_store #(
	parameter int DEPTH = bf3_pkg::DEFAULT_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = 2 * bf3_pkg::PIX_W
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] mem_q;
	logic [DW-1:0] fwd_q;
	logic          hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_q <= mem[rd_addr];
			hit_q <= wr_en && (wr_addr == rd_addr);
			fwd_q <= wr_data;
		end
	end

	assign rd_data = hit_q ? fwd_q : mem_q;

endmodule

FILE: rtl/bf3_window.sv
// ----------------------------------------------------------------------------
// bf3_window
// 3x3 pixel window, nine-input sum and output register.
// ----------------------------------------------------------------------------
module bf3_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  bf3_pkg::pos_t               pos,
	input  logic [bf3_pkg::PIX_W-1:0]   top,
	input  logic [bf3_pkg::PIX_W-1:0]   mid,
	input  logic [bf3_pkg::PIX_W-1:0]   pix,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [bf3_pkg::SUM_W-1:0]   out_sum,
	output logic                        out_last
);

	// row 0 = top, 1 = middle, 2 = current; column 2 is the newest
	logic [bf3_pkg::PIX_W-1:0] win_q [3][3];
	logic [bf3_pkg::PIX_W-1:0] new_col [3];
	logic [bf3_pkg::SUM_W-1:0] sum_next;

	assign new_col[0] = top;
	assign new_col[1] = mid;
	assign new_col[2] = pix;

	always_comb begin
		sum_next = '0;
		for (int k = 0; k < 3; k++) begin
			sum_next = sum_next + bf3_pkg::SUM_W'(win_q[k][1])
				+ bf3_pkg::SUM_W'(win_q[k][2]) + bf3_pkg::SUM_W'(new_col[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else if (shift) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
				win_q[k][2] <= new_col[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (shift && pos.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && pos.emit) begin
			out_sum  <= sum_next;
			out_last <= pos.last;
		end
	end

endmodule
